>>> hw/rtl/rocauc_pkg.sv
// Shared types and constants for the pairwise ROC AUC core.
package rocauc_pkg;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_COMPARE,
    ST_SETTLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_EMIT
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the incoming sample
    logic pair_init;  // clear pair score and pair indices
    logic pair_step;  // issue the next pair read
    logic div_init;   // load the divider
    logic div_step;   // one restoring division step
    logic clear_set;  // reset counts and drop flag
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic degenerate;
    logic pair_last;
    logic div_done;
  } dp_status_t;

endpackage

>>> hw/rtl/rocauc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rocauc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/rocauc_datapath.sv
// Sample stores, pair comparison accumulator and result divider.
module rocauc_datapath import rocauc_pkg::*; #(
  parameter int MaxSamples   = 1024,
  parameter int ScoreBits    = 32,
  parameter int FractionBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          score_i,
  input  logic                 label_i,
  input  dp_cmd_t              cmd_i,
  output dp_status_t           status_o,
  output logic [16:0]          auc_fraction_o,
  output logic [19:0]          pair_score_o,
  output logic [10:0]          positives_o,
  output logic [10:0]          negatives_o,
  output logic                 degenerate_o,
  output logic                 overflow_o
);

  localparam int AddrW  = $clog2(MaxSamples);
  localparam int CntW   = $clog2(MaxSamples + 1);
  localparam int PsW    = 2 * CntW + 1;
  localparam int NumW   = PsW + FractionBits;
  localparam int DivW   = $clog2(NumW + 1);

  logic [CntW-1:0]  pos_cnt_q, neg_cnt_q;
  logic             drop_q;
  logic [AddrW-1:0] pi_q, ni_q;
  logic             rd_valid_q;
  logic [PsW-1:0]   ps_q;
  logic [NumW-1:0]  quo_q;
  logic [PsW:0]     rem_q;
  logic [PsW-1:0]   den_q;
  logic [DivW-1:0]  dcnt_q;
  logic [ScoreBits-1:0] key, pos_rd, neg_rd;
  logic [CntW:0]    total;
  logic             full, pi_end, ni_end;

  // Offset-binary key so unsigned order follows signed order.
  always_comb begin
    key = ScoreBits'(score_i);
    key[ScoreBits-1] = ~key[ScoreBits-1];
  end

  assign total = {1'b0, pos_cnt_q} + {1'b0, neg_cnt_q};
  assign full  = total >= (CntW+1)'(MaxSamples);

  rocauc_ram #(.Width(ScoreBits), .Depth(MaxSamples)) u_pos_ram (
    .clk_i, .we_i(cmd_i.load && !full && label_i), .waddr_i(pos_cnt_q[AddrW-1:0]),
    .wdata_i(key), .raddr_i(pi_q), .rdata_o(pos_rd));
  rocauc_ram #(.Width(ScoreBits), .Depth(MaxSamples)) u_neg_ram (
    .clk_i, .we_i(cmd_i.load && !full && !label_i), .waddr_i(neg_cnt_q[AddrW-1:0]),
    .wdata_i(key), .raddr_i(ni_q), .rdata_o(neg_rd));

  // Sample counters and drop flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q <= '0;
      neg_cnt_q <= '0;
      drop_q    <= 1'b0;
    end else if (cmd_i.clear_set) begin
      pos_cnt_q <= '0;
      neg_cnt_q <= '0;
      drop_q    <= 1'b0;
    end else if (cmd_i.load) begin
      if (full) drop_q <= 1'b1;
      else if (label_i) pos_cnt_q <= pos_cnt_q + 1'b1;
      else neg_cnt_q <= neg_cnt_q + 1'b1;
    end
  end

  assign ni_end = ({1'b0, ni_q} + 1'b1) == (AddrW+1)'(neg_cnt_q);
  assign pi_end = ({1'b0, pi_q} + 1'b1) == (AddrW+1)'(pos_cnt_q);

  // Pair walk: one read per cycle, compare on the registered data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pi_q <= '0;
      ni_q <= '0;
      rd_valid_q <= 1'b0;
      ps_q <= '0;
    end else begin
      rd_valid_q <= cmd_i.pair_step;
      if (rd_valid_q) begin
        if (pos_rd > neg_rd) ps_q <= ps_q + PsW'(2);
        else if (pos_rd == neg_rd) ps_q <= ps_q + PsW'(1);
      end
      if (cmd_i.pair_init) begin
        pi_q <= '0;
        ni_q <= '0;
        ps_q <= '0;
      end else if (cmd_i.pair_step) begin
        if (ni_end) begin
          ni_q <= '0;
          pi_q <= pi_q + 1'b1;
        end else begin
          ni_q <= ni_q + 1'b1;
        end
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [PsW:0] trial;
  assign trial = {rem_q[PsW-1:0], quo_q[NumW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_init) begin
      dcnt_q <= DivW'(NumW);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= {ps_q, FractionBits'(0)};
      rem_q <= '0;
      den_q <= PsW'({pos_cnt_q, 1'b0}) * PsW'(neg_cnt_q);
    end else if (cmd_i.div_step && dcnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign status_o.degenerate = (pos_cnt_q == '0) || (neg_cnt_q == '0);
  assign status_o.pair_last  = pi_end && ni_end;
  assign status_o.div_done   = dcnt_q == '0;

  assign auc_fraction_o = status_o.degenerate ? '0 : 17'(quo_q);
  assign pair_score_o   = status_o.degenerate ? '0 : 20'(ps_q);
  assign positives_o    = 11'(pos_cnt_q);
  assign negatives_o    = 11'(neg_cnt_q);
  assign degenerate_o   = status_o.degenerate;
  assign overflow_o     = drop_q;

  // The stores together never exceed capacity.
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CntW+1)'(MaxSamples)) else $error("sample count beyond capacity");
  // A read result only follows an issued read.
  a_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(cmd_i.pair_step)) else $error("spurious read valid");
  // A divider load always sets the step count to the full quotient width.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_init |=> dcnt_q == DivW'(NumW)) else $error("divider load lost");

endmodule

>>> hw/rtl/rocauc_ctrl.sv
// Controller state machine for loading, pair walking, division and result.
module rocauc_ctrl import rocauc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       last_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy,
  output logic       done_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign accept = start && !busy;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_i) state_d = ST_PRIME;
      end
      ST_PRIME: begin
        state_d = status_i.degenerate ? ST_EMIT : ST_COMPARE;
      end
      ST_COMPARE: begin
        if (status_i.pair_last) state_d = ST_SETTLE;
      end
      ST_SETTLE: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        cmd_o.load = accept;
      end
      ST_PRIME: cmd_o.pair_init = 1'b1;
      ST_COMPARE: cmd_o.pair_step = 1'b1;
      // The final pair read is accounted in this cycle.
      ST_SETTLE: busy = 1'b1;
      // The pair score is complete, so the divider can take it.
      ST_LOAD: cmd_o.div_init = 1'b1;
      ST_DIVIDE: cmd_o.div_step = 1'b1;
      ST_EMIT: begin
        done_o = 1'b1;
        cmd_o.clear_set = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result while idle");
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result");
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == ST_IDLE) else $error("load while busy");

endmodule

>>> hw/rtl/roc_auc_pairwise_core.sv
// Top level of the pairwise ROC AUC core.
// Usage: drive score_i, label_i and last_i with start high while busy is low;
// the sample is taken at that clock edge, one per cycle while loading.
// Samples go to a positive or negative store; MaxSamples fit in total and any
// beyond are dropped and flagged on the result as overflow_o.
// A sample with last_i set ends the set. The core then primes the pair walk,
// compares every stored positive with every negative, one pair per cycle
// from the two store RAMs, settles the last compare, loads the divider and
// runs the restoring divider, after which done_o rises. When a class is
// empty it goes from priming straight to the result. busy is high
// throughout, so sets are handled one after another.
// The result is shown for one cycle with done_o high; the receiver cannot
// stall and must take it then. Counts clear after the result.
// Reset clears counts and control; store contents need no clearing.
module roc_auc_pairwise_core import rocauc_pkg::*; #(
  parameter int MaxSamples   = 1024,
  parameter int ScoreBits    = 32,
  parameter int FractionBits = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] score_i,
  input  logic        label_i,
  input  logic        last_i,
  output logic        done_o,
  output logic [16:0] auc_fraction_o,
  output logic [19:0] pair_score_o,
  output logic [10:0] positives_o,
  output logic [10:0] negatives_o,
  output logic        degenerate_o,
  output logic        overflow_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rocauc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .last_i, .status_i(status),
    .cmd_o(cmd), .busy, .done_o);

  rocauc_datapath #(.MaxSamples(MaxSamples), .ScoreBits(ScoreBits),
    .FractionBits(FractionBits)) u_dp (
    .clk_i, .rst_ni, .score_i, .label_i, .cmd_i(cmd), .status_o(status),
    .auc_fraction_o, .pair_score_o, .positives_o, .negatives_o,
    .degenerate_o, .overflow_o);

endmodule

>>> tb/roc_auc_pairwise_checker.sv
// Scoreboard for the pairwise ROC AUC core: predicts each result and compares it.
module roc_auc_pairwise_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [31:0] score_i,
  input  logic        label_i,
  input  logic        last_i,
  input  logic        done_i,
  input  logic [16:0] auc_fraction_i,
  input  logic [19:0] pair_score_i,
  input  logic [10:0] positives_i,
  input  logic [10:0] negatives_i,
  input  logic        degenerate_i,
  input  logic        overflow_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          degenerate_seen_o,
  output int          overflow_seen_o
);

  localparam int Capacity = 1024;

  typedef struct packed {
    logic [16:0] auc_fraction;
    logic [19:0] pair_score;
    logic [10:0] positives;
    logic [10:0] negatives;
    logic        degenerate;
    logic        overflow;
  } auc_result_t;

  // Sample stores and counts of the set being loaded.
  logic signed [31:0] pos_scores[Capacity];
  logic signed [31:0] neg_scores[Capacity];
  int unsigned        pos_cnt;
  int unsigned        neg_cnt;
  logic               dropped;
  auc_result_t        auc_expected_q[$];

  // Close the current set and work out the result it must produce.
  function automatic auc_result_t evaluate_set();
    auc_result_t r;
    longint unsigned score_sum;
    score_sum = 0;
    r = '0;
    r.positives = pos_cnt[10:0];
    r.negatives = neg_cnt[10:0];
    r.overflow  = dropped;
    r.degenerate = (pos_cnt == 0) || (neg_cnt == 0);
    if (!r.degenerate) begin
      for (int i = 0; i < pos_cnt; i++) begin
        for (int j = 0; j < neg_cnt; j++) begin
          if (pos_scores[i] > neg_scores[j]) begin
            score_sum += 2;
          end else if (pos_scores[i] == neg_scores[j]) begin
            score_sum += 1;
          end
        end
      end
      r.pair_score   = score_sum[19:0];
      r.auc_fraction = 17'((score_sum << 16) / (64'(2) * pos_cnt * neg_cnt));
    end
    return r;
  endfunction

  // Accept transactions, predict, and compare each result against the oldest one.
  always @(posedge clk_i or negedge rst_ni) begin
    auc_result_t exp_r;
    auc_result_t got;
    if (!rst_ni) begin
      pos_cnt = 0;
      neg_cnt = 0;
      dropped = 1'b0;
      auc_expected_q.delete();
      errors_o = 0;
      results_o = 0;
      degenerate_seen_o = 0;
      overflow_seen_o = 0;
    end else begin
      if (done_i) begin
        got = {auc_fraction_i, pair_score_i, positives_i, negatives_i,
               degenerate_i, overflow_i};
        results_o++;
        if (degenerate_i) degenerate_seen_o++;
        if (overflow_i) overflow_seen_o++;
        if (auc_expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("ERROR: unexpected result %p", got);
        end else begin
          exp_r = auc_expected_q.pop_front();
          if (got !== exp_r) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("ERROR: result mismatch");
              $display("  expected %p", exp_r);
              $display("  actual   %p", got);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        if (pos_cnt + neg_cnt >= Capacity) begin
          dropped = 1'b1;
        end else if (label_i) begin
          pos_scores[pos_cnt] = score_i;
          pos_cnt++;
        end else begin
          neg_scores[neg_cnt] = score_i;
          neg_cnt++;
        end
        if (last_i) begin
          auc_expected_q.push_back(evaluate_set());
          pos_cnt = 0;
          neg_cnt = 0;
          dropped = 1'b0;
        end
      end
    end
    pending_o = auc_expected_q.size();
  end

endmodule

>>> tb/tb_roc_auc_pairwise_core.sv
// Top of the pairwise ROC AUC testbench: clock, reset, stimulus and verdict.
module tb_roc_auc_pairwise_core;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] score_i;
  logic        label_i;
  logic        last_i;
  logic        done_o;
  logic [16:0] auc_fraction_o;
  logic [19:0] pair_score_o;
  logic [10:0] positives_o;
  logic [10:0] negatives_o;
  logic        degenerate_o;
  logic        overflow_o;

  int errors;
  int pending;
  int results;
  int degenerate_seen;
  int overflow_seen;
  int burst_left;
  int samples_sent;

  roc_auc_pairwise_core dut (
    .clk_i, .rst_ni, .start, .busy, .score_i, .label_i, .last_i, .done_o,
    .auc_fraction_o, .pair_score_o, .positives_o, .negatives_o,
    .degenerate_o, .overflow_o
  );

  roc_auc_pairwise_checker u_checker (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy), .score_i, .label_i, .last_i,
    .done_i(done_o), .auc_fraction_i(auc_fraction_o), .pair_score_i(pair_score_o),
    .positives_i(positives_o), .negatives_i(negatives_o),
    .degenerate_i(degenerate_o), .overflow_i(overflow_o),
    .errors_o(errors), .pending_o(pending), .results_o(results),
    .degenerate_seen_o(degenerate_seen), .overflow_seen_o(overflow_seen)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Send one sample; bursts of back-to-back transactions with random gaps between.
  task automatic send_sample(input logic [31:0] score, input logic label,
                             input logic last);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
    end
    burst_left--;
    start   <= 1'b1;
    score_i <= score;
    label_i <= label;
    last_i  <= last;
    // Busy only moves on a rising edge, so its value here holds to the next edge.
    while (busy) @(negedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // Scores drawn so that ties and near values are common.
  function automatic logic [31:0] pick_score();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 15)) - 8);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  // Stimulus.
  initial begin
    int set_len;
    start = 1'b0;
    score_i = '0;
    label_i = 1'b0;
    last_i = 1'b0;
    burst_left = 0;
    samples_sent = 0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Degenerate sets: a lone positive, a lone negative.
    send_sample(32'h0001_0000, 1'b1, 1'b1);
    send_sample(32'h8000_0000, 1'b0, 1'b1);
    // Only negatives, then only positives.
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h0000_0001, 1'b1, 1'b1);
    // Extremes: perfect separation, then fully inverted.
    send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h8000_0000, 1'b0, 1'b1);
    send_sample(32'h8000_0000, 1'b1, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0, 1'b1);
    // All ties, with the set closed by a negative.
    send_sample(32'hFFFF_8000, 1'b1, 1'b0);
    send_sample(32'hFFFF_8000, 1'b1, 1'b0);
    send_sample(32'hFFFF_8000, 1'b0, 1'b0);
    send_sample(32'hFFFF_8000, 1'b0, 1'b1);
    // Mixed signs around zero, giving a fraction that truncates.
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(32'h0000_0000, 1'b0, 1'b0);
    send_sample(32'h0000_0002, 1'b1, 1'b0);
    send_sample(32'h0000_0001, 1'b0, 1'b0);
    send_sample(32'h0000_0002, 1'b0, 1'b0);
    send_sample(32'h5555_AAAA, 1'b1, 1'b1);

    // Random sets, mostly small.
    while (samples_sent < 280) begin
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                            : $urandom_range(1, 12);
      for (int k = 0; k < set_len; k++) begin
        send_sample(pick_score(), 1'($urandom_range(0, 1)), k == set_len - 1);
      end
    end

    // Capacity: fill the stores with a skewed class mix, then drop a few samples.
    for (int k = 0; k < 1030; k++) begin
      send_sample(pick_score(), (k % 128) != 5, k == 1029);
    end
    // A short set afterwards proves the counts and drop flag cleared.
    send_sample(pick_score(), 1'b0, 1'b0);
    send_sample(pick_score(), 1'b1, 1'b1);
    start <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("Sent %0d samples; checked %0d results (%0d degenerate, %0d with overflow).",
             samples_sent, results, degenerate_seen, overflow_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
